>>> hdl/bksf_pkg.sv
// Types and constants shared by the knot span finder files.
`timescale 1ns / 1ps
`default_nettype none

package bksf_pkg;

    localparam int KNOT_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int GEN_W      = 8;
    localparam int ORDER_W    = 5;
    localparam int LAST_W     = 6;
    localparam int INDEX_W    = 6;
    localparam int SEG_W      = 7;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd4;
    localparam logic [LAST_W-1:0]  LAST_RESET  = 6'd3;
    localparam logic [KNOT_W-1:0]  START_RESET = 32'd0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 2'd0,
        OP_GENERATE = 2'd1,
        OP_FIND     = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_SPAN = 2'd1,
        ST_BEYOND  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER = 2'd0,
        REG_LAST  = 2'd1,
        REG_START = 2'd2
    } t_reg;

endpackage

`default_nettype wire

>>> hdl/bksf_if.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface bksf_in_if
    import bksf_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [INDEX_W-1:0]       knot_index;
    logic signed [KNOT_W-1:0] knot_value;
    logic signed [KNOT_W-1:0] param_value;

    modport source (output valid, op, knot_index, knot_value, param_value, input ready);
    modport sink (input valid, op, knot_index, knot_value, param_value, output ready);
endinterface

interface bksf_out_if
    import bksf_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic [INDEX_W-1:0]      span_index;
    logic signed [SEG_W-1:0] segment_number;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, span_index, segment_number, status, input ready);
    modport sink (input valid, span_index, segment_number, status, output ready);
endinterface

`default_nettype wire

>>> hdl/bksf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module bksf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output      logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/bspline_knot_span_finder.sv
// Top level of the B-spline knot span finder: knot store, generator and span search.
//
//  Channel   Direction  Beat contents
//  i_in      in         op, knot_index, knot_value, param_value
//  o_out     out        span_index, segment_number, status
//  i_cfg_*   in         register index and write data, no handshake
//
// A write passes the start and done states, a generate also writes count knots and a find
// reads up to count stored knots, where count is last_control_index + spline_order + 1.
// The search reads one stored knot per cycle through the single read port of the knot RAM.
// Reset is synchronous; the knot store is not cleared and reads as undefined until written.
// A finished result waits in the output register; a new beat is taken once the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module bspline_knot_span_finder
    import bksf_pkg::*;
#(
    parameter int MAX_KNOTS   = 64,
    parameter int EPSILON_LSB = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    bksf_in_if.sink                    i_in,
    bksf_out_if.source                 o_out
);

    localparam int AW     = $clog2(MAX_KNOTS);
    localparam int CW_RAW = $clog2(MAX_KNOTS + 1);
    localparam int CW     = (CW_RAW > 7) ? CW_RAW : 7;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_KNOTS);
    localparam logic [KNOT_W:0] EPS_C = (KNOT_W + 1)'(EPSILON_LSB);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_GEN,
        S_FIND,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [ORDER_W-1:0]       r_order;
    logic [LAST_W-1:0]        r_last;
    logic signed [KNOT_W-1:0] r_start;

    logic [OP_W-1:0]          r_op;
    logic [INDEX_W-1:0]       r_kidx;
    logic [KNOT_W-1:0]        r_kval;
    logic signed [KNOT_W-1:0] r_param;
    logic signed [KNOT_W-1:0] r_prev;
    logic                     r_first;
    logic [CW-1:0]            r_cnt;

    logic [INDEX_W-1:0]       r_res_span;
    logic [SEG_W-1:0]         r_res_seg;
    t_status                  r_res_status;

    logic                     r_out_valid;
    logic [INDEX_W-1:0]       r_out_span;
    logic [SEG_W-1:0]         r_out_seg;
    logic [STATUS_W-1:0]      r_out_status;

    logic [CW-1:0]            w_count;
    logic                     w_beyond;
    logic signed [KNOT_W:0]   w_diff;
    logic [KNOT_W:0]          w_abs;
    logic                     w_near;
    logic signed [GEN_W-1:0]  w_gen_t;
    logic [KNOT_W-1:0]        w_gen_knot;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [KNOT_W-1:0]        w_wdata;
    logic [KNOT_W-1:0]        w_rdata;
    logic signed [KNOT_W-1:0] w_cur;
    logic                     w_hit;
    logic                     w_accept;

    assign w_count  = CW'(r_last) + CW'(r_order) + CW'(1);
    assign w_beyond = w_count > MAX_C;
    assign w_diff   = {r_param[KNOT_W-1], r_param} - {r_start[KNOT_W-1], r_start};
    assign w_abs    = w_diff[KNOT_W] ? (KNOT_W + 1)'(-w_diff) : (KNOT_W + 1)'(w_diff);
    assign w_near   = w_abs < EPS_C;

    always_comb begin
        if (r_cnt < CW'(r_order)) begin
            w_gen_t = '0;
        end else if (r_cnt <= CW'(r_last)) begin
            w_gen_t = GEN_W'(r_cnt) - GEN_W'(r_order) + GEN_W'(1);
        end else begin
            w_gen_t = GEN_W'(r_last) - GEN_W'(r_order) + GEN_W'(2);
        end
    end

    assign w_gen_knot = {{(KNOT_W - GEN_W - FRAC_W){w_gen_t[GEN_W-1]}}, w_gen_t,
                         {FRAC_W{1'b0}}};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_kidx);
        w_wdata = r_kval;
        if (r_state == S_START && r_op == OP_WRITE && CW'(r_kidx) < MAX_C) begin
            w_we = 1'b1;
        end else if (r_state == S_GEN) begin
            w_we    = 1'b1;
            w_waddr = r_cnt[AW-1:0];
            w_wdata = w_gen_knot;
        end
    end

    bksf_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (MAX_KNOTS)
    ) u_knot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_cur    = w_rdata;
    assign w_hit    = (r_param >= r_prev) && (r_param <= w_cur);
    assign w_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_last  <= LAST_RESET;
            r_start <= START_RESET;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_ORDER: r_order <= i_cfg_data[ORDER_W-1:0];
                REG_LAST:  r_last  <= i_cfg_data[LAST_W-1:0];
                REG_START: r_start <= i_cfg_data[KNOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_in.op;
                        r_kidx  <= i_in.knot_index;
                        r_kval  <= i_in.knot_value;
                        r_param <= i_in.param_value;
                        r_cnt   <= '0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_res_seg <= '0;
                    case (r_op)
                        OP_WRITE: begin
                            r_res_span   <= '0;
                            r_res_status <= (CW'(r_kidx) >= MAX_C) ? ST_BEYOND : ST_OK;
                            r_state      <= S_DONE;
                        end
                        OP_GENERATE: begin
                            r_res_span   <= '0;
                            r_res_status <= w_beyond ? ST_BEYOND : ST_OK;
                            r_state      <= w_beyond ? S_DONE : S_GEN;
                        end
                        OP_FIND: begin
                            if (w_beyond) begin
                                r_res_span   <= '0;
                                r_res_status <= ST_BEYOND;
                                r_state      <= S_DONE;
                            end else if (w_near) begin
                                r_res_span   <= INDEX_W'(r_order) - INDEX_W'(1);
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end else if (w_count < CW'(2)) begin
                                r_res_span   <= '0;
                                r_res_status <= ST_NO_SPAN;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_span   <= '0;
                                r_res_status <= ST_OK;
                                r_cnt        <= CW'(1);
                                r_first      <= 1'b1;
                                r_state      <= S_FIND;
                            end
                        end
                        default: begin
                            r_res_span   <= '0;
                            r_res_status <= ST_OK;
                            r_state      <= S_DONE;
                        end
                    endcase
                end
                S_GEN: begin
                    if (r_cnt == w_count - CW'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_FIND: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_first) begin
                        r_prev  <= w_cur;
                        r_first <= 1'b0;
                    end else if (w_hit) begin
                        r_res_span <= INDEX_W'(r_cnt - CW'(2));
                        r_res_seg  <= SEG_W'(r_cnt - CW'(1) - CW'(r_order));
                        r_state    <= S_DONE;
                    end else begin
                        r_prev <= w_cur;
                        if (r_cnt == w_count) begin
                            r_res_status <= ST_NO_SPAN;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_span   <= r_res_span;
                        r_out_seg    <= r_res_seg;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.span_index     = r_out_span;
    assign o_out.segment_number = r_out_seg;
    assign o_out.status         = r_out_status;

endmodule

`default_nettype wire
